/* src/dtrg_pkg.sv */
// ----------------------------------------------------------------------------
// dtrg_pkg
// Types, constants and register codes shared by the dual tone generator.
// ----------------------------------------------------------------------------
package dtrg_pkg;

  localparam int COEF_W    = 22;   // coefficient / seed register width
  localparam int TONE_W    = 24;   // resonator state width, Q4.20
  localparam int FRAC_W    = 20;   // fractional bits
  localparam int CODE_W    = 10;   // DAC and ADC code width
  localparam int BYTE_W    = 8;
  localparam int FRAME_W   = 7;    // frame counter width
  localparam int ADDR_W    = 4;    // APB byte address width
  localparam int DATA_W    = 32;

  localparam int FRAME_LEN_DEF   = 125;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int SCALE_MUL  = 400;
  localparam int CODE_OFS   = 500;
  localparam int CODE_MAX   = 1023;
  localparam int CODE_RESET = 512;
  localparam int LO_OFS     = 11;
  localparam int HI_OFS     = 51;
  localparam int TERM_BYTE  = 10;

  // register index, paddr[3:2]
  typedef enum logic [1:0] {
    REG_COEF_A = 2'd0,
    REG_COEF_B = 2'd1,
    REG_SEED_A = 2'd2,
    REG_SEED_B = 2'd3
  } reg_idx_t;

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] adc_sample;
  } item_t;

  typedef struct packed {
    logic [CODE_W-1:0] dac_code;
    logic [BYTE_W-1:0] tx_byte;
    logic              last;
  } res_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] seed_a;
    logic signed [COEF_W-1:0] seed_b;
  } cfg_t;

  // one tick's work, handed from the front to the byte serializer
  typedef struct packed {
    logic [CODE_W-1:0] sent;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] sample;
    logic              term;
  } entry_t;

  typedef enum logic [2:0] {
    SEL_CODE_LO = 3'd0,
    SEL_CODE_HI = 3'd1,
    SEL_ADC_LO  = 3'd2,
    SEL_ADC_HI  = 3'd3,
    SEL_TERM    = 3'd4
  } byte_sel_t;

endpackage

/* src/dual_tone_resonator_generator.sv */
// ----------------------------------------------------------------------------
// dual_tone_resonator_generator
// Two Q4.20 resonators summed into a 10-bit DAC code plus framed serial bytes.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item, item_valid, item_stall): kind 0 is a sample tick that
//   carries adc_sample, kind 1 reloads both resonators from seed_a / seed_b.
//   res channel (res, res_valid, res_stall): per tick four bytes (code low,
//   code high, sample low, sample high), plus a terminator byte 10 after
//   every FRAME_LEN ticks; last marks the final byte and dac_code holds the
//   code of the previous tick on all of them.
//   APB port writes coef_a, coef_b, seed_a, seed_b at 0x0, 0x4, 0x8, 0xC;
//   write only while the block is idle.
// Timing:
//   A tick passes the front-end steps multiply, resonator update and scale
//   and is then pushed into the queue; a restart reloads both resonators.
//   The serializer emits one byte per cycle while res is not stalled; the
//   front end takes a new item only when idle or while pushing a tick.
//   A QUEUE_DEPTH-entry queue (default 2) decouples front end and serializer.
// Reset: resonators cleared, held code 512, frame count 0, registers 0.
// A stalled res holds its byte; the queue then fills and item_stall rises.
// ----------------------------------------------------------------------------
module dual_tone_resonator_generator #(
  parameter int FRAME_LEN   = dtrg_pkg::FRAME_LEN_DEF,
  parameter int QUEUE_DEPTH = dtrg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dtrg_pkg::ADDR_W-1:0] paddr,
  input  logic [dtrg_pkg::DATA_W-1:0] pwdata,
  output logic [dtrg_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  dtrg_pkg::item_t             item,
  input  logic                        item_valid,
  output logic                        item_stall,
  output dtrg_pkg::res_t              res,
  output logic                        res_valid,
  input  logic                        res_stall
);
  import dtrg_pkg::*;

  cfg_t     cfg;
  reg_idx_t idx;
  logic     wr_en;
  logic     push, pop, q_full, q_empty;
  entry_t   push_data, head;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_COEF_A: cfg.coef_a <= pwdata[COEF_W-1:0];
        REG_COEF_B: cfg.coef_b <= pwdata[COEF_W-1:0];
        REG_SEED_A: cfg.seed_a <= pwdata[COEF_W-1:0];
        REG_SEED_B: cfg.seed_b <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_COEF_A: prdata = DATA_W'(cfg.coef_a);
      REG_COEF_B: prdata = DATA_W'(cfg.coef_b);
      REG_SEED_A: prdata = DATA_W'(cfg.seed_a);
      REG_SEED_B: prdata = DATA_W'(cfg.seed_b);
      default:    prdata = '0;
    endcase
  end

  dtrg_front #(
    .FRAME_LEN (FRAME_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  dtrg_fifo #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (q_empty)
  );

  dtrg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .res       (res),
    .res_valid (res_valid),
    .res_stall (res_stall)
  );

endmodule

/* src/dtrg_fifo.sv */
// ----------------------------------------------------------------------------
// dtrg_fifo
// Short register queue between the tone front end and the byte serializer.
// ----------------------------------------------------------------------------
module dtrg_fifo #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import dtrg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* src/dtrg_front.sv */
// ----------------------------------------------------------------------------
// dtrg_front
// Accepts ticks and restarts, steps both resonators, scales the sum to a
// DAC code and pushes one frame entry per tick into the queue.
// ----------------------------------------------------------------------------
module dtrg_front #(
  parameter int FRAME_LEN = 125
) (
  input  logic            clk,
  input  logic            rst,
  input  dtrg_pkg::cfg_t  cfg,
  input  dtrg_pkg::item_t item,
  input  logic            item_valid,
  output logic            item_stall,
  output logic            push,
  output dtrg_pkg::entry_t push_data,
  input  logic            q_full
);
  import dtrg_pkg::*;

  localparam int PROD_W  = COEF_W + TONE_W;
  localparam int SUM_W   = TONE_W + 1;
  localparam int SCL_W   = SUM_W + 10;
  localparam int SH_W    = SCL_W - FRAC_W;
  localparam int BIAS_W  = SH_W + 1;

  typedef enum logic [1:0] {F_IDLE, F_STEP, F_SCALE, F_PUSH} fstate_t;

  fstate_t st;

  logic signed [TONE_W-1:0] a_p1, a_p2, b_p1, b_p2;
  logic signed [PROD_W-1:0] prod_a, prod_b;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SCL_W-1:0]  scaled;
  logic [CODE_W-1:0]        sample;
  logic [CODE_W-1:0]        held_code;
  logic [FRAME_W-1:0]       frame_count;

  logic signed [TONE_W-1:0] ya, yb;
  logic [CODE_W-1:0]        code_new;
  logic [FRAME_W-1:0]       frame_inc;
  logic                     term;
  logic                     accept;
  logic signed [BIAS_W-1:0] biased;

  function automatic logic signed [TONE_W-1:0] step_tone(
    input logic signed [PROD_W-1:0] prod,
    input logic signed [TONE_W-1:0] p2
  );
    logic signed [PROD_W-FRAC_W-1:0] shr;
    logic signed [PROD_W-FRAC_W:0]   diff;
    begin
      shr  = prod[PROD_W-1:FRAC_W];  // floor divide by 2^20
      diff = (PROD_W-FRAC_W+1)'(shr) - (PROD_W-FRAC_W+1)'(p2);
      if (diff > (PROD_W-FRAC_W+1)'((1 << (TONE_W - 1)) - 1)) begin
        step_tone = {1'b0, {(TONE_W-1){1'b1}}};
      end else if (diff < -(PROD_W-FRAC_W+1)'(1 << (TONE_W - 1))) begin
        step_tone = {1'b1, {(TONE_W-1){1'b0}}};
      end else begin
        step_tone = diff[TONE_W-1:0];
      end
    end
  endfunction

  assign ya = step_tone(prod_a, a_p2);
  assign yb = step_tone(prod_b, b_p2);

  assign biased = BIAS_W'($signed(scaled[SCL_W-1:FRAC_W])) + BIAS_W'(CODE_OFS);

  always_comb begin
    if (biased < 0) begin
      code_new = '0;
    end else if (biased > BIAS_W'(CODE_MAX)) begin
      code_new = CODE_W'(CODE_MAX);
    end else begin
      code_new = biased[CODE_W-1:0];
    end
  end

  assign frame_inc = frame_count + 1'b1;
  assign term      = (frame_inc >= FRAME_W'(FRAME_LEN));

  assign push       = (st == F_PUSH) && !q_full;
  assign item_stall = !((st == F_IDLE) || push);
  assign accept     = item_valid && !item_stall;

  assign push_data.sent   = held_code;
  assign push_data.code   = code_new;
  assign push_data.sample = sample;
  assign push_data.term   = term;

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= F_IDLE;
      a_p1        <= '0;
      a_p2        <= '0;
      b_p1        <= '0;
      b_p2        <= '0;
      held_code   <= CODE_W'(CODE_RESET);
      frame_count <= '0;
    end else begin
      case (st)
        F_IDLE, F_PUSH: begin
          if (push) begin
            held_code   <= code_new;
            frame_count <= term ? '0 : frame_inc;
          end
          if (accept) begin
            if (item.kind == KIND_RESTART) begin
              a_p1 <= TONE_W'(cfg.seed_a);
              a_p2 <= '0;
              b_p1 <= TONE_W'(cfg.seed_b);
              b_p2 <= '0;
              st   <= F_IDLE;
            end else begin
              prod_a <= PROD_W'(cfg.coef_a) * PROD_W'(a_p1);
              prod_b <= PROD_W'(cfg.coef_b) * PROD_W'(b_p1);
              sample <= item.adc_sample;
              st     <= F_STEP;
            end
          end else if (st == F_IDLE || push) begin
            st <= F_IDLE;
          end
        end
        F_STEP: begin
          a_p2 <= a_p1;
          a_p1 <= ya;
          b_p2 <= b_p1;
          b_p1 <= yb;
          sum  <= SUM_W'(ya) + SUM_W'(yb);
          st   <= F_SCALE;
        end
        F_SCALE: begin
          scaled <= SCL_W'(sum) * SCL_W'(SCALE_MUL);
          st     <= F_PUSH;
        end
        default: st <= F_IDLE;
      endcase
    end
  end

endmodule

/* src/dtrg_back.sv */
// ----------------------------------------------------------------------------
// dtrg_back
// Byte serializer: turns each queued tick entry into four framing bytes
// and, at the end of a frame, the terminator byte.
// ----------------------------------------------------------------------------
module dtrg_back (
  input  logic             clk,
  input  logic             rst,
  input  dtrg_pkg::entry_t head,
  input  logic             q_empty,
  output logic             pop,
  output dtrg_pkg::res_t   res,
  output logic             res_valid,
  input  logic             res_stall
);
  import dtrg_pkg::*;

  byte_sel_t         sel;
  logic              load;
  logic              last_now;
  logic [BYTE_W-1:0] byte_now;

  always_comb begin
    case (sel)
      SEL_CODE_LO: byte_now = BYTE_W'(head.code[4:0]) + BYTE_W'(LO_OFS);
      SEL_CODE_HI: byte_now = BYTE_W'(head.code[9:5]) + BYTE_W'(HI_OFS);
      SEL_ADC_LO:  byte_now = BYTE_W'(head.sample[4:0]) + BYTE_W'(LO_OFS);
      SEL_ADC_HI:  byte_now = BYTE_W'(head.sample[9:5]) + BYTE_W'(HI_OFS);
      SEL_TERM:    byte_now = BYTE_W'(TERM_BYTE);
      default:     byte_now = '0;
    endcase
  end

  assign last_now = (sel == SEL_TERM) || ((sel == SEL_ADC_HI) && !head.term);
  assign load     = !res_valid || !res_stall;
  assign pop      = load && !q_empty && last_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sel       <= SEL_CODE_LO;
    end else if (load) begin
      res_valid <= !q_empty;
      if (!q_empty) begin
        res.dac_code <= head.sent;
        res.tx_byte  <= byte_now;
        res.last     <= last_now;
        sel          <= last_now ? SEL_CODE_LO : byte_sel_t'(sel + 3'd1);
      end
    end
  end

endmodule
